// ----- design/goc_pkg.sv -----
// Shared types, constants and helper functions for the occupancy grid lookup.
// No dependencies; every other design file except goc_ram imports this package.
`timescale 1ns / 1ps

package goc_pkg;

    // Serial divider sizing: numerator 2*|diff|+|pitch| < 2^34, divisor 2*|pitch| <= 2^28.
    localparam int DIV_NW = 34;
    localparam int DIV_DW = 29;
    localparam int DIV_CW = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LNG_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LNG_PITCH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_PITCH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 3'd5;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_CELL   = 2'd1;
    localparam logic [1:0] MODE_COORD  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int CELL_POS_LIM = 32767;
    localparam int CELL_NEG_LIM = 32768;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [31:0] lng_origin;
        logic signed [30:0] lat_origin;
        logic signed [27:0] lng_pitch;
        logic signed [27:0] lat_pitch;
        logic [8:0]         col_count;
        logic [8:0]         row_count;
    } t_cfg;

    // One classified operation handed from the front end to the grid back end.
    typedef struct packed {
        logic               is_write;
        logic               bit_val;
        logic               valid;
        logic signed [15:0] col;
        logic signed [15:0] row;
    } t_cell_op;

    typedef struct packed {
        logic               strobe;
        logic               blocked;
        logic               on_grid;
        logic signed [15:0] col;
        logic signed [15:0] row;
    } t_result;

    typedef struct packed {
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
        logic              neg;
        logic              valid;
    } t_axis;

    // Operands for round(diff/pitch) half away from zero: (2|d| + |p|) / (2|p|).
    function automatic t_axis axis_setup(input logic signed [32:0] diff,
                                         input logic signed [27:0] pitch);
        logic [32:0] ad;
        logic [27:0] ap;
        t_axis       a;
        ad      = diff[32] ? 33'(-diff) : 33'(diff);
        ap      = pitch[27] ? 28'(-pitch) : 28'(pitch);
        a.num   = {ad, 1'b0} + DIV_NW'(ap);
        a.den   = {ap, 1'b0};
        a.neg   = diff[32] ^ pitch[27];
        a.valid = (pitch != '0);
        return a;
    endfunction

    // Applies the sign and clamps the magnitude to the 16-bit cell range.
    function automatic logic signed [15:0] sat_cell(input logic [DIV_NW-1:0] quo,
                                                    input logic neg);
        logic [16:0] mag;
        logic [15:0] res;
        mag = '0;
        if (neg) begin
            mag = (quo > DIV_NW'(CELL_NEG_LIM)) ? 17'(CELL_NEG_LIM) : quo[16:0];
            res = 16'(17'd0 - mag);
        end else begin
            res = (quo > DIV_NW'(CELL_POS_LIM)) ? 16'(CELL_POS_LIM) : quo[15:0];
        end
        return $signed(res);
    endfunction

endpackage

// ----- design/goc_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module goc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/goc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on goc_pkg for operand widths.
`timescale 1ns / 1ps

module goc_div
    import goc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_busy,
    output logic [DIV_NW-1:0] o_quo
);

    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic [DIV_DW:0]   w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_num[DIV_NW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    // The numerator shifts out at the top while quotient bits shift in at the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CW'(DIV_NW);
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NW-2:0], w_fit};
            r_rem <= w_fit ? DIV_DW'(w_trial - {1'b0, r_den}) : w_trial[DIV_DW-1:0];
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;

endmodule

// ----- design/goc_front.sv -----
// Front end: takes input beats, classifies them and turns coordinates into cells.
// Depends on goc_pkg and goc_div.
`timescale 1ns / 1ps

module goc_front
    import goc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_accept,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_cell_col,
    input  logic signed [15:0] i_cell_row,
    input  logic               i_cell_blocked,
    input  logic signed [31:0] i_coord_lng,
    input  logic signed [30:0] i_coord_lat,
    input  logic               i_full,
    output logic               o_idle,
    output logic               o_push,
    output t_cell_op           o_op
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH
    } t_state;

    t_state            r_state;
    t_cell_op          r_op;
    logic              r_neg_lng;
    logic              r_neg_lat;
    logic              r_vld_lng;
    logic              r_vld_lat;
    logic signed [32:0] w_dlng;
    logic signed [32:0] w_dlat;
    t_axis             w_ax_lng;
    t_axis             w_ax_lat;
    logic              w_div_start;
    logic              w_lng_busy;
    logic              w_lat_busy;
    logic [DIV_NW-1:0] w_lng_quo;
    logic [DIV_NW-1:0] w_lat_quo;

    assign w_dlng = $signed({i_coord_lng[31], i_coord_lng})
                  - $signed({i_cfg.lng_origin[31], i_cfg.lng_origin});
    assign w_dlat = $signed({{2{i_coord_lat[30]}}, i_coord_lat})
                  - $signed({{2{i_cfg.lat_origin[30]}}, i_cfg.lat_origin});

    assign w_ax_lng    = axis_setup(w_dlng, i_cfg.lng_pitch);
    assign w_ax_lat    = axis_setup(w_dlat, i_cfg.lat_pitch);
    assign w_div_start = (r_state == S_IDLE) && i_accept && (i_mode == MODE_COORD);

    goc_div u_div_lng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_ax_lng.num),
        .i_den   (w_ax_lng.den),
        .o_busy  (w_lng_busy),
        .o_quo   (w_lng_quo)
    );

    goc_div u_div_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_ax_lat.num),
        .i_den   (w_ax_lat.den),
        .o_busy  (w_lat_busy),
        .o_quo   (w_lat_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        priority if (i_mode == MODE_COORD) begin
                            r_neg_lng <= w_ax_lng.neg;
                            r_neg_lat <= w_ax_lat.neg;
                            r_vld_lng <= w_ax_lng.valid;
                            r_vld_lat <= w_ax_lat.valid;
                            r_state   <= S_DIV;
                        end else if (i_mode == MODE_WRITE || i_mode == MODE_CELL) begin
                            r_op.is_write <= (i_mode == MODE_WRITE);
                            r_op.bit_val  <= i_cell_blocked;
                            r_op.valid    <= 1'b1;
                            r_op.col      <= i_cell_col;
                            r_op.row      <= i_cell_row;
                            r_state       <= S_PUSH;
                        end else begin
                            // The unused mode is dropped without a result.
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    if (!w_lng_busy && !w_lat_busy) begin
                        r_op.is_write <= 1'b0;
                        r_op.bit_val  <= 1'b0;
                        r_op.valid    <= r_vld_lng && r_vld_lat;
                        r_op.col      <= r_vld_lng ? sat_cell(w_lng_quo, r_neg_lng) : '0;
                        r_op.row      <= r_vld_lat ? sat_cell(w_lat_quo, r_neg_lat) : '0;
                        r_state       <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_op   = r_op;

endmodule

// ----- design/goc_fifo.sv -----
// Short queue of cell operations between the front end and the grid back end.
// Depends on goc_pkg.
`timescale 1ns / 1ps

module goc_fifo
    import goc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_cell_op i_op,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_empty,
    output t_cell_op o_op
);

    t_cell_op          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    // The depth is a power of two, so the pointers wrap on their own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wptr] <= i_op;
                r_wptr        <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rptr];

endmodule

// ----- design/goc_back.sv -----
// Back end: range check, obstacle bitmap access, result register and clear sweep.
// Depends on goc_pkg and goc_ram.
`timescale 1ns / 1ps

module goc_back
    import goc_pkg::*;
#(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [8:0] i_col_count,
    input  logic [8:0] i_row_count,
    input  logic       i_empty,
    input  t_cell_op   i_op,
    output logic       o_pop,
    output logic       o_clearing,
    output t_result    o_res
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);

    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;
    logic              r_s1_vld;
    logic              r_s1_inside;
    logic signed [15:0] r_s1_col;
    logic signed [15:0] r_s1_row;
    t_result           r_res;
    logic              w_pop;
    logic              w_inside;
    logic [AW-1:0]     w_cell_addr;
    logic              w_we;
    logic [AW-1:0]     w_addr;
    logic              w_wdata;
    logic              w_rdata;

    assign w_pop = !r_clearing && !i_empty;

    // Comparing against both the register and the build limit equals comparing against the min.
    assign w_inside = i_op.valid && !i_op.col[15] && !i_op.row[15]
                   && ($unsigned(i_op.col) < {7'd0, i_col_count})
                   && ($unsigned(i_op.col) < 16'(MAX_COLS))
                   && ($unsigned(i_op.row) < {7'd0, i_row_count})
                   && ($unsigned(i_op.row) < 16'(MAX_ROWS));

    assign w_cell_addr = AW'(32'(i_op.row[RW-1:0]) * 32'(MAX_COLS) + 32'(i_op.col[CW-1:0]));

    assign w_we    = r_clearing || (w_pop && i_op.is_write && w_inside);
    assign w_addr  = r_clearing ? r_clr_addr : w_cell_addr;
    assign w_wdata = r_clearing ? 1'b0 : i_op.bit_val;

    goc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_vld     <= 1'b0;
            r_res.strobe <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1_vld     <= w_pop && !i_op.is_write;
            r_res.strobe <= r_s1_vld;
        end
        r_s1_inside   <= w_inside;
        r_s1_col      <= i_op.col;
        r_s1_row      <= i_op.row;
        r_res.blocked <= !r_s1_inside || w_rdata;
        r_res.on_grid <= r_s1_inside;
        r_res.col     <= r_s1_col;
        r_res.row     <= r_s1_row;
    end

    assign o_pop      = w_pop;
    assign o_clearing = r_clearing;
    assign o_res      = r_res;

endmodule

// ----- design/grid_occupancy_lookup.sv -----
// Occupancy grid lookup. A cell query goes straight to the queue; for a coordinate
// query two serial dividers set the pace. The next item is taken once the last one
// has been pushed into the queue, before its result. Reset: synchronous, active low;
// afterwards busy stays high while the bitmap is swept to free. Results are
// single-cycle strobes.
// Depends on goc_pkg, goc_front, goc_fifo and goc_back.
`timescale 1ns / 1ps

module grid_occupancy_lookup
    import goc_pkg::*;
#(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_mode,
    input  logic signed [15:0]    i_cell_col,
    input  logic signed [15:0]    i_cell_row,
    input  logic                  i_cell_blocked,
    input  logic signed [31:0]    i_coord_lng,
    input  logic signed [30:0]    i_coord_lat,
    output logic                  o_strobe,
    output logic                  o_blocked,
    output logic                  o_inside_res,
    output logic signed [15:0]    o_grid_col,
    output logic signed [15:0]    o_grid_row
);

    t_cfg     r_cfg;
    logic     w_accept;
    logic     w_front_idle;
    logic     w_push;
    t_cell_op w_push_op;
    logic     w_full;
    logic     w_empty;
    t_cell_op w_head_op;
    logic     w_pop;
    logic     w_clearing;
    t_result  w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lng_origin <= '0;
            r_cfg.lat_origin <= '0;
            r_cfg.lng_pitch  <= 28'sd1;
            r_cfg.lat_pitch  <= 28'sd1;
            r_cfg.col_count  <= 9'd256;
            r_cfg.row_count  <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LNG_ORIGIN: r_cfg.lng_origin <= $signed(i_cfg_data[31:0]);
                REG_LAT_ORIGIN: r_cfg.lat_origin <= $signed(i_cfg_data[30:0]);
                REG_LNG_PITCH:  r_cfg.lng_pitch  <= $signed(i_cfg_data[27:0]);
                REG_LAT_PITCH:  r_cfg.lat_pitch  <= $signed(i_cfg_data[27:0]);
                REG_COL_COUNT:  r_cfg.col_count  <= i_cfg_data[8:0];
                REG_ROW_COUNT:  r_cfg.row_count  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign busy     = w_clearing || !w_front_idle;
    assign w_accept = start && !busy;

    goc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (w_accept),
        .i_mode         (i_mode),
        .i_cell_col     (i_cell_col),
        .i_cell_row     (i_cell_row),
        .i_cell_blocked (i_cell_blocked),
        .i_coord_lng    (i_coord_lng),
        .i_coord_lat    (i_coord_lat),
        .i_full         (w_full),
        .o_idle         (w_front_idle),
        .o_push         (w_push),
        .o_op           (w_push_op)
    );

    goc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_op    (w_head_op)
    );

    goc_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_col_count (r_cfg.col_count),
        .i_row_count (r_cfg.row_count),
        .i_empty     (w_empty),
        .i_op        (w_head_op),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_res       (w_res)
    );

    assign o_strobe     = w_res.strobe;
    assign o_blocked    = w_res.blocked;
    assign o_inside_res = w_res.on_grid;
    assign o_grid_col   = w_res.col;
    assign o_grid_row   = w_res.row;

endmodule

// ----- design/goc_chk.sv -----
// Port-level checks for the occupancy grid lookup, bound to the top level.
// Depends on goc_pkg and on grid_occupancy_lookup being compiled first.
`timescale 1ns / 1ps

module goc_chk
    import goc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_mode,
    input logic               o_strobe,
    input logic               o_blocked,
    input logic               o_inside_res,
    input logic signed [15:0] o_grid_col,
    input logic signed [15:0] o_grid_row
);

    // Reset always starts a bitmap sweep, so the block reports busy right after it.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy not raised after reset");

    a_no_beat_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result beat right after reset");

    a_outside_is_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_inside_res |-> o_blocked)
        else $error("cell outside the grid reported free");

    a_inside_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_inside_res |-> !o_grid_col[15] && !o_grid_row[15])
        else $error("inside result with a negative cell");

    a_accept_holds_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_mode != MODE_UNUSED) |=> busy)
        else $error("busy not raised after an accepted beat");

endmodule

bind grid_occupancy_lookup goc_chk u_goc_chk (.*);
